>>> design/aqfb_pkg.sv
package aqfb_pkg;

  // Field widths
  localparam int MANT_W    = 24;            // significand with hidden bit
  localparam int REM_W     = MANT_W + 1;    // partial remainder
  localparam int NUM_CELLS = MANT_W + 2;    // quotient bits: 24 + guard + one spare
  localparam int EXP_W     = 11;            // signed exponent difference
  localparam int INT_W     = 13;            // rounded magnitude before saturation
  localparam int VAL_W     = 12;            // signed integer after saturation
  localparam int SUM_W     = 13;            // integer plus zero point

  // Latency sums the front-end stages, the divider cells and the back-end stages
  localparam int LATENCY   = 2 + NUM_CELLS + 3;

  localparam logic [INT_W-1:0]         MAG_CAP  = INT_W'(1023);
  localparam logic signed [SUM_W-1:0]  U_MAX    = SUM_W'(255);
  localparam logic signed [SUM_W-1:0]  U_MIN    = SUM_W'(0);
  localparam logic signed [SUM_W-1:0]  S_MAX    = SUM_W'(127);
  localparam logic signed [SUM_W-1:0]  S_MIN    = -SUM_W'(128);
  localparam logic signed [EXP_W-1:0]  EXP_SAT  = EXP_W'(11);
  localparam logic signed [EXP_W-1:0]  EXP_TINY = -EXP_W'(2);
  localparam logic [7:0]               EXP_MAX  = 8'hFF;

  typedef enum logic [1:0] {
    CFG_SCALE = 2'd0,
    CFG_ZERO  = 2'd1,
    CFG_SIGN  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        is_last;
  } in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_out;
  } out_t;

  typedef struct packed {
    logic [31:0]       scale_bits;
    logic signed [8:0] zp_offset;
    logic              signed_output;
  } cfg_t;

  // Beat traveling down the divider chain
  typedef struct packed {
    logic [REM_W-1:0]        rem;
    logic [MANT_W-1:0]       divisor;
    logic [NUM_CELLS-1:0]    quo;
    logic signed [EXP_W-1:0] exp;
    logic                    sign;
    logic                    is_nan;
    logic                    is_inf;
    logic                    is_zero;
    logic                    last;
  } div_t;

  // Leading zero count of a significand; zero input yields zero
  function automatic logic [4:0] lzc24(input logic [MANT_W-1:0] m);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < MANT_W; i++) begin
      if (m[i]) begin
        n = 5'(MANT_W - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

>>> design/affine_quantize_float_to_byte_top.sv
// Every beat accepted on start shows on out_valid, in the order it was taken.
// Throughput: one beat per cycle; busy stays low, so start may be held high.
// The latency is set by the 26-cell restoring divider chain, one quotient bit
// per cell, plus two unpack stages and three rounding/clamp stages.
// Reset (rst_n low, synchronous) drops all beats in flight and restores
// scale 1.0, zero point 0 and unsigned range; the receiver cannot stall.
module affine_quantize_float_to_byte_top (
  input  logic            clk,
  input  logic            rst_n,
  // element channel
  input  logic            start,
  output logic            busy,
  input  aqfb_pkg::in_t   in_item,
  // result channel
  output logic            out_valid,
  output aqfb_pkg::out_t  out_item,
  // register write channel
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  // The pipeline never stalls, so both request sides are always open
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic in_fire;
  assign in_fire = start & ~busy;

  // Configuration registers
  aqfb_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_bits    <= 32'h3F80_0000;
      cfg_r.zp_offset     <= '0;
      cfg_r.signed_output <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (aqfb_pkg::cfg_idx_t'(cfg_index))
        aqfb_pkg::CFG_SCALE: cfg_r.scale_bits    <= cfg_data;
        aqfb_pkg::CFG_ZERO:  cfg_r.zp_offset     <= cfg_data[8:0];
        aqfb_pkg::CFG_SIGN:  cfg_r.signed_output <= cfg_data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Unpack and normalize both operands
  logic           chain_v [aqfb_pkg::NUM_CELLS+1];
  aqfb_pkg::div_t chain_d [aqfb_pkg::NUM_CELLS+1];

  aqfb_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_fire),
    .in_item    (in_item),
    .scale_bits (cfg_r.scale_bits),
    .out_valid_r(chain_v[0]),
    .out_div_r  (chain_d[0])
  );

  // Divider chain: each cell advances its beat by one quotient bit
  for (genvar g = 0; g < aqfb_pkg::NUM_CELLS; g++) begin : g_cell
    aqfb_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (chain_v[g]),
      .in_div     (chain_d[g]),
      .out_valid_r(chain_v[g+1]),
      .out_div_r  (chain_d[g+1])
    );
  end

  // Round, saturate, add zero point, clamp
  aqfb_round u_round (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chain_v[aqfb_pkg::NUM_CELLS]),
    .in_div     (chain_d[aqfb_pkg::NUM_CELLS]),
    .cfg        (cfg_r),
    .out_valid_r(out_valid),
    .out_item_r (out_item)
  );

  // Every accepted beat emerges after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##(aqfb_pkg::LATENCY) out_valid)
    else $error("accepted beat did not emerge");

  // No result without a matching accepted beat
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, aqfb_pkg::LATENCY))
    else $error("result without accepted beat");

  // Last mark follows its beat through the chain
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last_out == $past(in_item.is_last, aqfb_pkg::LATENCY)))
    else $error("last mark misaligned");

  // Unsigned mode with a nonnegative zero point never produces a NaN-like wrap:
  // a zero element must map to the zero point itself
  a_zero_elem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_fire && (in_item.value_bits[30:0] == '0)
                        && (cfg_r.scale_bits[30:0] != '0)
                        && (cfg_r.scale_bits[30:23] != 8'hFF)
                        && !cfg_r.signed_output && !cfg_r.zp_offset[8],
                        aqfb_pkg::LATENCY))
    |-> (out_item.code_byte == cfg_r.zp_offset[7:0]))
    else $error("zero element did not map to zero point");

endmodule

>>> design/aqfb_unpack.sv
module aqfb_unpack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  aqfb_pkg::in_t      in_item,
  input  logic [31:0]        scale_bits,
  output logic               out_valid_r,
  output aqfb_pkg::div_t     out_div_r
);

  // Stage 1: classify, expose significands, count leading zeros
  logic                          v1_r;
  logic [aqfb_pkg::MANT_W-1:0]   ma_r, mb_r;
  logic [7:0]                    ea_r, eb_r;
  logic [4:0]                    lza_r, lzb_r;
  logic                          sign_r, nan_r, inf_r, zero_r, last_r;

  logic [7:0]                    a_exp, b_exp;
  logic [22:0]                   a_frac, b_frac;
  logic                          a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [aqfb_pkg::MANT_W-1:0]   ma, mb;
  logic                          nan_c, inf_c;

  always_comb begin
    a_exp  = in_item.value_bits[30:23];
    a_frac = in_item.value_bits[22:0];
    b_exp  = scale_bits[30:23];
    b_frac = scale_bits[22:0];
    a_nan  = (a_exp == aqfb_pkg::EXP_MAX) && (a_frac != '0);
    a_inf  = (a_exp == aqfb_pkg::EXP_MAX) && (a_frac == '0);
    a_zero = (a_exp == '0) && (a_frac == '0);
    b_nan  = (b_exp == aqfb_pkg::EXP_MAX) && (b_frac != '0);
    b_inf  = (b_exp == aqfb_pkg::EXP_MAX) && (b_frac == '0);
    b_zero = (b_exp == '0) && (b_frac == '0);
    ma     = {(a_exp != '0), a_frac};
    mb     = {(b_exp != '0), b_frac};
    nan_c  = a_nan | b_nan | (a_zero & b_zero) | (a_inf & b_inf);
    inf_c  = ~nan_c & (a_inf | b_zero);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    ma_r   <= ma;
    mb_r   <= mb;
    ea_r   <= (a_exp == '0) ? 8'd1 : a_exp;
    eb_r   <= (b_exp == '0) ? 8'd1 : b_exp;
    lza_r  <= aqfb_pkg::lzc24(ma);
    lzb_r  <= aqfb_pkg::lzc24(mb);
    sign_r <= in_item.value_bits[31] ^ scale_bits[31];
    nan_r  <= nan_c;
    inf_r  <= inf_c;
    zero_r <= ~nan_c & ~inf_c & (a_zero | b_inf);
    last_r <= in_item.is_last;
  end

  // Stage 2: normalize and form the exponent difference
  aqfb_pkg::div_t div_nxt;

  always_comb begin
    div_nxt.rem     = {1'b0, ma_r << lza_r};
    div_nxt.divisor = mb_r << lzb_r;
    div_nxt.quo     = '0;
    div_nxt.exp     = $signed({3'b000, ea_r}) - $signed({6'b0, lza_r})
                    - $signed({3'b000, eb_r}) + $signed({6'b0, lzb_r});
    div_nxt.sign    = sign_r;
    div_nxt.is_nan  = nan_r;
    div_nxt.is_inf  = inf_r;
    div_nxt.is_zero = zero_r;
    div_nxt.last    = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v1_r;
    end
    out_div_r <= div_nxt;
  end

endmodule

>>> design/aqfb_cell.sv
module aqfb_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  aqfb_pkg::div_t  in_div,
  output logic            out_valid_r,
  output aqfb_pkg::div_t  out_div_r
);

  // One restoring step: compare, subtract, shift in one quotient bit
  logic [aqfb_pkg::REM_W-1:0]  diff;
  logic                        ge;
  logic [aqfb_pkg::MANT_W-1:0] kept;
  aqfb_pkg::div_t              div_nxt;

  always_comb begin
    diff        = in_div.rem - {1'b0, in_div.divisor};
    ge          = in_div.rem >= {1'b0, in_div.divisor};
    kept        = ge ? diff[aqfb_pkg::MANT_W-1:0] : in_div.rem[aqfb_pkg::MANT_W-1:0];
    div_nxt     = in_div;
    div_nxt.rem = {kept, 1'b0};
    div_nxt.quo = {in_div.quo[aqfb_pkg::NUM_CELLS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
    out_div_r <= div_nxt;
  end

endmodule

>>> design/aqfb_round.sv
module aqfb_round (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  aqfb_pkg::div_t  in_div,
  input  aqfb_pkg::cfg_t  cfg,
  output logic            out_valid_r,
  output aqfb_pkg::out_t  out_item_r
);

  // Stage A: round the quotient to a binary32 significand
  logic                           va_r;
  logic [aqfb_pkg::MANT_W:0]      sa_r;
  logic signed [aqfb_pkg::EXP_W-1:0] ea_r;
  logic                           sign_a_r, nan_a_r, inf_a_r, zero_a_r, last_a_r;

  logic [aqfb_pkg::MANT_W-1:0]    sig;
  logic                           grd, sticky, inc_a;
  logic signed [aqfb_pkg::EXP_W-1:0] e_nxt;

  always_comb begin
    if (in_div.quo[aqfb_pkg::NUM_CELLS-1]) begin
      sig    = in_div.quo[aqfb_pkg::NUM_CELLS-1:2];
      grd    = in_div.quo[1];
      sticky = in_div.quo[0] | (|in_div.rem);
      e_nxt  = in_div.exp;
    end else begin
      sig    = in_div.quo[aqfb_pkg::NUM_CELLS-2:1];
      grd    = in_div.quo[0];
      sticky = |in_div.rem;
      e_nxt  = in_div.exp - aqfb_pkg::EXP_W'(1);
    end
    inc_a = grd & (sticky | sig[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
    sa_r     <= {1'b0, sig} + {{aqfb_pkg::MANT_W{1'b0}}, inc_a};
    ea_r     <= e_nxt;
    sign_a_r <= in_div.sign;
    nan_a_r  <= in_div.is_nan;
    inf_a_r  <= in_div.is_inf;
    zero_a_r <= in_div.is_zero;
    last_a_r <= in_div.last;
  end

  // Stage B: round to integer, ties to even, and saturate
  logic                              vb_r;
  logic signed [aqfb_pkg::VAL_W-1:0] rb_r;
  logic                              nan_b_r, last_b_r;

  logic [4:0]                        sh;
  logic [2*aqfb_pkg::REM_W-1:0]      full;
  logic [aqfb_pkg::INT_W-1:0]        mag, mag_sat;
  logic                              sat, tiny, inc_b;

  always_comb begin
    sat   = inf_a_r | (~zero_a_r & (ea_r >= aqfb_pkg::EXP_SAT));
    tiny  = zero_a_r | (ea_r <= aqfb_pkg::EXP_TINY);
    sh    = 5'(aqfb_pkg::EXP_W'(23) - ea_r);
    full  = {sa_r, {aqfb_pkg::REM_W{1'b0}}} >> sh;
    inc_b = full[aqfb_pkg::REM_W-1]
          & ((|full[aqfb_pkg::REM_W-2:0]) | full[aqfb_pkg::REM_W]);
    mag   = full[aqfb_pkg::REM_W+aqfb_pkg::INT_W-1:aqfb_pkg::REM_W]
          + {{(aqfb_pkg::INT_W-1){1'b0}}, inc_b};
    if (sat) begin
      mag_sat = aqfb_pkg::MAG_CAP;
    end else if (tiny) begin
      mag_sat = '0;
    end else if (mag > aqfb_pkg::MAG_CAP) begin
      mag_sat = aqfb_pkg::MAG_CAP;
    end else begin
      mag_sat = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    rb_r     <= sign_a_r ? -$signed(mag_sat[aqfb_pkg::VAL_W-1:0])
                         : $signed(mag_sat[aqfb_pkg::VAL_W-1:0]);
    nan_b_r  <= nan_a_r;
    last_b_r <= last_a_r;
  end

  // Stage C: add zero point (a NaN yields the zero point), clamp to the selected byte range
  logic signed [aqfb_pkg::SUM_W-1:0] zp, sum, lo, hi, res;
  aqfb_pkg::out_t                    item_nxt;

  always_comb begin
    zp  = aqfb_pkg::SUM_W'(cfg.zp_offset);
    sum = nan_b_r ? zp : (aqfb_pkg::SUM_W'(rb_r) + zp);
    lo  = cfg.signed_output ? aqfb_pkg::S_MIN : aqfb_pkg::U_MIN;
    hi  = cfg.signed_output ? aqfb_pkg::S_MAX : aqfb_pkg::U_MAX;
    if (sum < lo) begin
      res = lo;
    end else if (sum > hi) begin
      res = hi;
    end else begin
      res = sum;
    end
    item_nxt.code_byte = res[7:0];
    item_nxt.last_out  = last_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vb_r;
    end
    out_item_r <= item_nxt;
  end

endmodule
